// ===== hdl/mta_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers of the mesh tangent accumulator.
// No dependencies; every other file imports this package.
package mta_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int IDX_W        = 10;
    localparam int COORD_W      = 32;
    localparam int OUT_W        = 16;
    localparam int SUM_WIDTH    = 48;
    localparam int FRAC_BITS    = 16;

    // fixed-point divide of num * 2^16 / det
    localparam int DIV_W    = 64;
    localparam int QBITS    = SUM_WIDTH - 1;
    localparam int HI_SHIFT = QBITS - FRAC_BITS;
    localparam int STEP_W   = $clog2(QBITS + 1);

    // normalization
    localparam int NORM_TOP    = 29;
    localparam int ONE_Q14     = 16384;
    localparam int Q14_SHIFT   = 14;
    localparam int NDIV_STEPS  = 15;
    localparam int NDVD_W      = NORM_TOP + 1 + Q14_SHIFT + 1;
    localparam int LEN_W       = 32;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    // input op codes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_TRI   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // classified command kinds
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_TRI   = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_MISS  = 2'd3;

    typedef struct packed {
        logic [1:0]                kind;
        logic [IDX_W-1:0]          index;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic signed [COORD_W-1:0] tex_u;
        logic signed [COORD_W-1:0] tex_v;
        logic [IDX_W-1:0]          c0;
        logic [IDX_W-1:0]          c1;
        logic [IDX_W-1:0]          c2;
    } cmd_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  rem;
        logic [QBITS-1:0]  low;
        logic [DIV_W-1:0]  divisor;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [QBITS-1:0] quot;
    } div_rsp_t;

    function automatic logic idx_in_range(input logic [IDX_W-1:0] i);
        return 32'(i) < 32'(MAX_VERTICES);
    endfunction

endpackage

// ===== hdl/mta_queue.sv =====
`timescale 1ns / 1ps
// Short command queue between the front and back ends.
// Depends on mta_pkg (cmd_t, QUEUE_DEPTH).
module mta_queue
    import mta_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_data,
    input  logic rd_en,
    output cmd_t rd_data,
    output logic full,
    output logic empty
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_wr;
    logic              do_rd;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    function automatic logic [QPTR_W-1:0] wrap_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            if (do_rd)
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ===== hdl/mta_front.sv =====
`timescale 1ns / 1ps
// Front end: takes input items, checks indices and turns them into commands.
// Depends on mta_pkg (cmd_t, op and command codes).
module mta_front
    import mta_pkg::*;
(
    input  logic                      push,
    output logic                      full,
    input  logic [1:0]                op,
    input  logic [IDX_W-1:0]          vertex_index,
    input  logic signed [COORD_W-1:0] pos_x,
    input  logic signed [COORD_W-1:0] pos_y,
    input  logic signed [COORD_W-1:0] pos_z,
    input  logic signed [COORD_W-1:0] tex_u,
    input  logic signed [COORD_W-1:0] tex_v,
    input  logic [IDX_W-1:0]          corner0,
    input  logic [IDX_W-1:0]          corner1,
    input  logic [IDX_W-1:0]          corner2,
    input  logic                      q_full,
    input  logic                      clearing,
    output logic                      q_wr,
    output cmd_t                      q_data
);

    logic accept;
    logic keep;
    logic idx_ok;

    assign full   = q_full || clearing;
    assign accept = push && !full;
    assign idx_ok = idx_in_range(vertex_index);
    assign q_wr   = accept && keep;

    always_comb
    begin
        q_data.index = vertex_index;
        q_data.pos_x = pos_x;
        q_data.pos_y = pos_y;
        q_data.pos_z = pos_z;
        q_data.tex_u = tex_u;
        q_data.tex_v = tex_v;
        q_data.c0    = corner0;
        q_data.c1    = corner1;
        q_data.c2    = corner2;
        case (op)
            OP_WRITE:
            begin
                q_data.kind = CMD_WRITE;
                keep        = idx_ok;
            end
            OP_TRI:
            begin
                q_data.kind = CMD_TRI;
                keep        = idx_in_range(corner0) && idx_in_range(corner1)
                              && idx_in_range(corner2);
            end
            OP_READ:
            begin
                // an out-of-range read still answers, flagged as zero length
                q_data.kind = idx_ok ? CMD_READ : CMD_MISS;
                keep        = 1'b1;
            end
            default:
            begin
                q_data.kind = CMD_MISS;
                keep        = 1'b0;
            end
        endcase
    end

endmodule

// ===== hdl/mta_div.sv =====
`timescale 1ns / 1ps
// Shared restoring divider, one quotient bit per cycle.
// Depends on mta_pkg (div_req_t, div_rsp_t, widths).
module mta_div
    import mta_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  dvs_reg;
    logic [QBITS-1:0]  low_reg;
    logic [QBITS-1:0]  quot_reg;
    logic [STEP_W-1:0] left_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIV_W-1:0]  shifted;
    logic [DIV_W-1:0]  diff;
    logic              ge;

    // remainder stays below the divisor, so its top bit is always clear
    assign shifted = {rem_reg[DIV_W-2:0], low_reg[QBITS-1]};
    assign ge      = (shifted >= dvs_reg);
    assign diff    = shifted - dvs_reg;

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            left_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                left_reg <= req.steps;
            end
            else if (busy_reg)
            begin
                left_reg <= left_reg - 1'b1;
                if (left_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= req.rem;
            low_reg  <= req.low;
            dvs_reg  <= req.divisor;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? diff : shifted;
            low_reg  <= low_reg << 1;
            quot_reg <= {quot_reg[QBITS-2:0], ge};
        end
    end

endmodule

// ===== hdl/mta_back.sv =====
`timescale 1ns / 1ps
// Back end: vertex and tangent memories, triangle and normalize sequencer,
// shared multiplier, square root and result register. Depends on mta_pkg.
module mta_back
    import mta_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cmd_valid,
    input  cmd_t                    cmd,
    output logic                    cmd_take,
    output logic                    clearing,
    output div_req_t                div_req,
    input  div_rsp_t                div_rsp,
    input  logic                    out_pop,
    output logic                    out_valid,
    output logic signed [OUT_W-1:0] out_x,
    output logic signed [OUT_W-1:0] out_y,
    output logic signed [OUT_W-1:0] out_z,
    output logic                    out_zl
);

    localparam logic [4:0] S_CLEAR     = 5'd0;
    localparam logic [4:0] S_IDLE      = 5'd1;
    localparam logic [4:0] S_TRI_RD    = 5'd2;
    localparam logic [4:0] S_TRI_CAP   = 5'd3;
    localparam logic [4:0] S_DIFF      = 5'd4;
    localparam logic [4:0] S_MUL       = 5'd5;
    localparam logic [4:0] S_DET       = 5'd6;
    localparam logic [4:0] S_TDIV_GO   = 5'd7;
    localparam logic [4:0] S_TDIV_WAIT = 5'd8;
    localparam logic [4:0] S_ACC_RD    = 5'd9;
    localparam logic [4:0] S_ACC_WR    = 5'd10;
    localparam logic [4:0] S_RD_RD     = 5'd11;
    localparam logic [4:0] S_RD_CAP    = 5'd12;
    localparam logic [4:0] S_NORM      = 5'd13;
    localparam logic [4:0] S_SQ        = 5'd14;
    localparam logic [4:0] S_SQRT      = 5'd15;
    localparam logic [4:0] S_NDIV_GO   = 5'd16;
    localparam logic [4:0] S_NDIV_WAIT = 5'd17;
    localparam logic [4:0] S_OUT       = 5'd18;

    localparam int POS_ROW_W = 3 * COORD_W;
    localparam int TEX_ROW_W = 2 * COORD_W;
    localparam int SUM_ROW_W = 3 * SUM_WIDTH;
    localparam int PROD_W    = 2 * COORD_W;

    // memories
    logic [POS_ROW_W-1:0] pos_mem [MAX_VERTICES];
    logic [TEX_ROW_W-1:0] tex_mem [MAX_VERTICES];
    logic [SUM_ROW_W-1:0] sum_mem [MAX_VERTICES];
    logic [POS_ROW_W-1:0] pos_rd_reg;
    logic [TEX_ROW_W-1:0] tex_rd_reg;
    logic [SUM_ROW_W-1:0] sum_rd_reg;
    logic                 vtx_we;
    logic [ADDR_W-1:0]    vtx_waddr;
    logic [ADDR_W-1:0]    vtx_raddr;
    logic                 sum_we;
    logic [ADDR_W-1:0]    sum_waddr;
    logic [ADDR_W-1:0]    sum_raddr;
    logic [SUM_ROW_W-1:0] sum_wdata;

    // control
    logic [4:0]        state_reg, state_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_load;

    // datapath
    cmd_t                       cmd_reg;
    logic signed [COORD_W-1:0]  pos_c_reg [3][3];
    logic signed [COORD_W-1:0]  tex_c_reg [3][2];
    logic signed [COORD_W-1:0]  e1_reg [3];
    logic signed [COORD_W-1:0]  e2_reg [3];
    logic signed [COORD_W-1:0]  du1_reg, dv1_reg, du2_reg, dv2_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   acc_reg;
    logic signed [PROD_W-1:0]   det_reg;
    logic signed [PROD_W-1:0]   num_reg [3];
    logic                       neg_reg;
    logic signed [SUM_WIDTH-1:0] tan_reg [3];
    logic [SUM_WIDTH-1:0]       mag_reg [3];
    logic                       sgn_reg [3];
    logic [DIV_W-1:0]           sq_acc_reg, sq_v_reg, sq_res_reg, sq_bit_reg;
    logic [LEN_W-1:0]           len_reg;
    logic signed [OUT_W-1:0]    comp_reg [3];
    logic                       zl_reg;
    logic signed [OUT_W-1:0]    out_x_reg, out_y_reg, out_z_reg;
    logic                       out_zl_reg;

    // combinational helpers
    logic [1:0]                 sel;
    logic [IDX_W-1:0]           corner_sel;
    logic signed [COORD_W-1:0]  mul_a, mul_b;
    logic [3:0]                 mul_j;
    logic [1:0]                 slot_j;
    logic [DIV_W-1:0]           n_mag, d_mag;
    logic                       t_neg, t_sat;
    logic signed [SUM_WIDTH-1:0] q_signed;
    logic [SUM_WIDTH-1:0]       mag_or;
    logic [SUM_ROW_W-1:0]       acc_row;
    logic signed [SUM_WIDTH-1:0] rd_comp [3];
    logic                       rd_zero;
    logic [DIV_W-1:0]           sq_t, sq_v_n, sq_res_n;
    logic                       sq_ge;
    logic [NDVD_W-1:0]          ndvd;
    logic [NDIV_STEPS-1:0]      r_raw;
    logic [OUT_W-1:0]           r_clamp;

    function automatic logic signed [COORD_W-1:0] sat_sub(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b);
        logic signed [COORD_W:0] d;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        if (d[COORD_W] != d[COORD_W-1])
            return d[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        return d[COORD_W-1:0];
    endfunction

    function automatic logic signed [SUM_WIDTH-1:0] sat_add(
        input logic signed [SUM_WIDTH-1:0] a,
        input logic signed [SUM_WIDTH-1:0] b);
        logic signed [SUM_WIDTH:0] s;
        s = {a[SUM_WIDTH-1], a} + {b[SUM_WIDTH-1], b};
        if (s[SUM_WIDTH] != s[SUM_WIDTH-1])
            return s[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
        return s[SUM_WIDTH-1:0];
    endfunction

    assign sel = cnt_reg[1:0];

    always_comb
    begin
        case (sel)
            2'd0:    corner_sel = cmd_reg.c0;
            2'd1:    corner_sel = cmd_reg.c1;
            default: corner_sel = cmd_reg.c2;
        endcase
    end

    // ---------------- memories ----------------
    always_ff @(posedge clk)
    begin
        if (vtx_we)
        begin
            pos_mem[vtx_waddr] <= {cmd.pos_z, cmd.pos_y, cmd.pos_x};
            tex_mem[vtx_waddr] <= {cmd.tex_v, cmd.tex_u};
        end
        pos_rd_reg <= pos_mem[vtx_raddr];
        tex_rd_reg <= tex_mem[vtx_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (sum_we)
            sum_mem[sum_waddr] <= sum_wdata;
        sum_rd_reg <= sum_mem[sum_raddr];
    end

    // ---------------- multiplier operands ----------------
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_SQ)
        begin
            mul_a = COORD_W'(mag_reg[sel][NORM_TOP:0]);
            mul_b = COORD_W'(mag_reg[sel][NORM_TOP:0]);
        end
        else
        begin
            case (cnt_reg[2:0])
                3'd0:
                begin
                    mul_a = du1_reg;
                    mul_b = dv2_reg;
                end
                3'd1:
                begin
                    mul_a = dv1_reg;
                    mul_b = du2_reg;
                end
                default:
                begin
                    if (!cnt_reg[0])
                    begin
                        mul_a = e1_reg[cnt_reg[2:1] - 2'd1];
                        mul_b = dv2_reg;
                    end
                    else
                    begin
                        mul_a = e2_reg[cnt_reg[2:1] - 2'd1];
                        mul_b = dv1_reg;
                    end
                end
            endcase
        end
    end

    assign mul_j  = cnt_reg - 4'd1;
    assign slot_j = mul_j[2:1];

    // ---------------- triangle divide setup ----------------
    assign t_neg  = num_reg[sel][PROD_W-1] != det_reg[PROD_W-1];
    assign n_mag  = num_reg[sel][PROD_W-1] ? DIV_W'(-num_reg[sel]) : DIV_W'(num_reg[sel]);
    assign d_mag  = det_reg[PROD_W-1] ? DIV_W'(-det_reg) : DIV_W'(det_reg);
    // quotient would not fit SUM_WIDTH bits
    assign t_sat  = (n_mag >> HI_SHIFT) >= d_mag;
    assign q_signed = neg_reg ? -$signed({1'b0, div_rsp.quot}) : $signed({1'b0, div_rsp.quot});

    // ---------------- accumulate and read rows ----------------
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            rd_comp[k] = sum_rd_reg[k*SUM_WIDTH +: SUM_WIDTH];
            acc_row[k*SUM_WIDTH +: SUM_WIDTH] = sat_add(rd_comp[k], tan_reg[k]);
        end
    end

    assign rd_zero = (sum_rd_reg == '0);
    assign mag_or  = mag_reg[0] | mag_reg[1] | mag_reg[2];

    // ---------------- square root step ----------------
    assign sq_t     = sq_res_reg + sq_bit_reg;
    assign sq_ge    = sq_v_reg >= sq_t;
    assign sq_v_n   = sq_ge ? sq_v_reg - sq_t : sq_v_reg;
    assign sq_res_n = sq_ge ? (sq_res_reg >> 1) + sq_bit_reg : sq_res_reg >> 1;

    // ---------------- normalize divide setup ----------------
    assign ndvd    = (NDVD_W'(mag_reg[sel][NORM_TOP:0]) << Q14_SHIFT)
                     + NDVD_W'(len_reg >> 1);
    assign r_raw   = div_rsp.quot[NDIV_STEPS-1:0];
    assign r_clamp = (32'(r_raw) > 32'(ONE_Q14)) ? OUT_W'(ONE_Q14) : OUT_W'(r_raw);

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        clr_cnt_next   = clr_cnt_reg;
        cmd_take       = 1'b0;
        vtx_we         = 1'b0;
        vtx_waddr      = ADDR_W'(cmd.index);
        vtx_raddr      = ADDR_W'(corner_sel);
        sum_we         = 1'b0;
        sum_waddr      = ADDR_W'(corner_sel);
        sum_raddr      = ADDR_W'(corner_sel);
        sum_wdata      = '0;
        out_load       = 1'b0;
        div_req.start  = 1'b0;
        div_req.rem    = DIV_W'(n_mag >> HI_SHIFT);
        div_req.low    = QBITS'(n_mag << FRAC_BITS);
        div_req.divisor = d_mag;
        div_req.steps  = STEP_W'(QBITS);

        case (state_reg)
            S_CLEAR:
            begin
                sum_we       = 1'b1;
                sum_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(MAX_VERTICES - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                cnt_next = '0;
                if (cmd_valid)
                begin
                    cmd_take = 1'b1;
                    case (cmd.kind)
                        CMD_WRITE:
                        begin
                            vtx_we    = 1'b1;
                            sum_we    = 1'b1;
                            sum_waddr = ADDR_W'(cmd.index);
                        end
                        CMD_TRI:  state_next = S_TRI_RD;
                        CMD_READ: state_next = S_RD_RD;
                        default:  state_next = S_OUT;
                    endcase
                end
            end
            S_TRI_RD:
                state_next = S_TRI_CAP;
            S_TRI_CAP:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (sel == 2'd2)
                begin
                    cnt_next   = '0;
                    state_next = S_DIFF;
                end
                else
                    state_next = S_TRI_RD;
            end
            S_DIFF:
                state_next = S_MUL;
            S_MUL:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd8)
                begin
                    cnt_next   = '0;
                    state_next = S_DET;
                end
            end
            S_DET:
                state_next = (det_reg == '0) ? S_IDLE : S_TDIV_GO;
            S_TDIV_GO:
            begin
                if (t_sat)
                begin
                    cnt_next = cnt_reg + 4'd1;
                    if (sel == 2'd2)
                    begin
                        cnt_next   = '0;
                        state_next = S_ACC_RD;
                    end
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = S_TDIV_WAIT;
                end
            end
            S_TDIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    cnt_next   = cnt_reg + 4'd1;
                    state_next = S_TDIV_GO;
                    if (sel == 2'd2)
                    begin
                        cnt_next   = '0;
                        state_next = S_ACC_RD;
                    end
                end
            end
            S_ACC_RD:
                state_next = S_ACC_WR;
            S_ACC_WR:
            begin
                sum_we    = 1'b1;
                sum_wdata = acc_row;
                cnt_next  = cnt_reg + 4'd1;
                state_next = (sel == 2'd2) ? S_IDLE : S_ACC_RD;
            end
            S_RD_RD:
            begin
                sum_raddr  = ADDR_W'(cmd_reg.index);
                state_next = S_RD_CAP;
            end
            S_RD_CAP:
                state_next = rd_zero ? S_OUT : S_NORM;
            S_NORM:
            begin
                cnt_next = '0;
                if ((mag_or[SUM_WIDTH-1:NORM_TOP+1] == '0) && mag_or[NORM_TOP])
                    state_next = S_SQ;
            end
            S_SQ:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd3)
                begin
                    cnt_next   = '0;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (sq_bit_reg[0])
                    state_next = S_NDIV_GO;
            end
            S_NDIV_GO:
            begin
                div_req.start   = 1'b1;
                div_req.rem     = DIV_W'(ndvd >> NDIV_STEPS);
                div_req.low     = {ndvd[NDIV_STEPS-1:0], {(QBITS-NDIV_STEPS){1'b0}}};
                div_req.divisor = DIV_W'(len_reg);
                div_req.steps   = STEP_W'(NDIV_STEPS);
                state_next      = S_NDIV_WAIT;
            end
            S_NDIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    cnt_next   = cnt_reg + 4'd1;
                    state_next = (sel == 2'd2) ? S_OUT : S_NDIV_GO;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_pop)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_pop)
            out_valid_next = 1'b0;
        if (out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (cmd_take)
            cmd_reg <= cmd;
        if (out_load)
        begin
            out_x_reg  <= comp_reg[0];
            out_y_reg  <= comp_reg[1];
            out_z_reg  <= comp_reg[2];
            out_zl_reg <= zl_reg;
        end

        case (state_reg)
            S_IDLE:
            begin
                // a miss answers with a zero-length result
                zl_reg <= 1'b1;
                for (int k = 0; k < 3; k++)
                    comp_reg[k] <= '0;
            end
            S_TRI_CAP:
            begin
                for (int k = 0; k < 3; k++)
                    pos_c_reg[sel][k] <= pos_rd_reg[k*COORD_W +: COORD_W];
                for (int k = 0; k < 2; k++)
                    tex_c_reg[sel][k] <= tex_rd_reg[k*COORD_W +: COORD_W];
            end
            S_DIFF:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    e1_reg[k] <= sat_sub(pos_c_reg[1][k], pos_c_reg[0][k]);
                    e2_reg[k] <= sat_sub(pos_c_reg[2][k], pos_c_reg[0][k]);
                end
                du1_reg <= sat_sub(tex_c_reg[1][0], tex_c_reg[0][0]);
                dv1_reg <= sat_sub(tex_c_reg[1][1], tex_c_reg[0][1]);
                du2_reg <= sat_sub(tex_c_reg[2][0], tex_c_reg[0][0]);
                dv2_reg <= sat_sub(tex_c_reg[2][1], tex_c_reg[0][1]);
            end
            S_MUL:
            begin
                // product of the previous step is in prod_reg
                if (cnt_reg != 4'd0)
                begin
                    if (!mul_j[0])
                        acc_reg <= prod_reg;
                    else if (slot_j == 2'd0)
                        det_reg <= acc_reg - prod_reg;
                    else
                        num_reg[slot_j - 2'd1] <= acc_reg - prod_reg;
                end
            end
            S_TDIV_GO:
            begin
                neg_reg <= t_neg;
                if (t_sat)
                    tan_reg[sel] <= t_neg ? SUM_MIN : SUM_MAX;
            end
            S_TDIV_WAIT:
            begin
                if (div_rsp.done)
                    tan_reg[sel] <= q_signed;
            end
            S_RD_CAP:
            begin
                zl_reg <= rd_zero;
                for (int k = 0; k < 3; k++)
                begin
                    sgn_reg[k] <= rd_comp[k][SUM_WIDTH-1];
                    mag_reg[k] <= rd_comp[k][SUM_WIDTH-1] ? SUM_WIDTH'(-rd_comp[k])
                                                          : SUM_WIDTH'(rd_comp[k]);
                end
            end
            S_NORM:
            begin
                if (mag_or[SUM_WIDTH-1:NORM_TOP+1] != '0)
                begin
                    for (int k = 0; k < 3; k++)
                        mag_reg[k] <= mag_reg[k] >> 1;
                end
                else if (!mag_or[NORM_TOP])
                begin
                    for (int k = 0; k < 3; k++)
                        mag_reg[k] <= mag_reg[k] << 1;
                end
            end
            S_SQ:
            begin
                if (cnt_reg == 4'd0)
                    sq_acc_reg <= '0;
                else if (cnt_reg == 4'd3)
                begin
                    sq_v_reg   <= sq_acc_reg + DIV_W'(prod_reg);
                    sq_res_reg <= '0;
                    sq_bit_reg <= DIV_W'(1) << (DIV_W - 2);
                end
                else
                    sq_acc_reg <= sq_acc_reg + DIV_W'(prod_reg);
            end
            S_SQRT:
            begin
                sq_v_reg   <= sq_v_n;
                sq_res_reg <= sq_res_n;
                sq_bit_reg <= sq_bit_reg >> 2;
                if (sq_bit_reg[0])
                    len_reg <= LEN_W'(sq_res_n);
            end
            S_NDIV_WAIT:
            begin
                if (div_rsp.done)
                    comp_reg[sel] <= sgn_reg[sel] ? -$signed(r_clamp) : $signed(r_clamp);
            end
            default:
            begin
            end
        endcase
    end

    assign clearing  = (state_reg == S_CLEAR);
    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_z     = out_z_reg;
    assign out_zl    = out_zl_reg;

    // ---------------- assertions ----------------
    a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !cmd_take)
        else $error("command taken during clearing pass");

    a_norm_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SQ) |-> ((mag_or[SUM_WIDTH-1:NORM_TOP+1] == '0) && mag_or[NORM_TOP]))
        else $error("magnitudes not normalized before squaring");

    a_div_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider restarted while busy");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_pop) |=> (out_valid_reg && $stable(out_x_reg)
                                          && $stable(out_zl_reg)))
        else $error("waiting result overwritten");

    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (($signed(out_x_reg) <= OUT_W'(ONE_Q14))
                           && ($signed(out_x_reg) >= -$signed(OUT_W'(ONE_Q14)))))
        else $error("tangent component out of unit range");

endmodule

// ===== hdl/mesh_tangent_accumulator.sv =====
`timescale 1ns / 1ps
// Top level of the mesh tangent accumulator: front end, command queue,
// back end and shared divider. Depends on mta_pkg and all mta_* modules.
//
// Keeps a 1024-vertex table of Q16.16 positions and texture coordinates and
// a saturating 48-bit tangent sum per vertex. Items enter through a queue
// style port (push/full) and read_tangent results leave through another
// (empty/pop); the front end classifies items and drops the ones that have
// no effect, then a short command queue lets it keep accepting while the
// back end works and while a result waits to be popped. Commands execute one
// at a time in the back end, whose memories have one read and one write port.
// After reset a clearing pass zeroes the tangent sums, one vertex per cycle;
// full stays high during it. In the back end, write_vertex is done in the
// idle state; add_triangle ends after the determinant step when the UV
// determinant is zero, and otherwise runs the bit-serial divider once per
// axis (47 quotient bits, three axes) unless that quotient saturates;
// read_tangent runs the one-bit-per-cycle normalize shift, the square root
// and three 15-bit divides. Unused op codes, out-of-range writes or triangles
// are dropped at the front end and cost nothing downstream. Vertices used by
// a triangle must have been written first.
module mesh_tangent_accumulator
    import mta_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [1:0]                op,
    input  logic [IDX_W-1:0]          vertex_index,
    input  logic signed [COORD_W-1:0] pos_x,
    input  logic signed [COORD_W-1:0] pos_y,
    input  logic signed [COORD_W-1:0] pos_z,
    input  logic signed [COORD_W-1:0] tex_u,
    input  logic signed [COORD_W-1:0] tex_v,
    input  logic [IDX_W-1:0]          corner0,
    input  logic [IDX_W-1:0]          corner1,
    input  logic [IDX_W-1:0]          corner2,
    output logic                      empty,
    input  logic                      pop,
    output logic signed [OUT_W-1:0]   tangent_x,
    output logic signed [OUT_W-1:0]   tangent_y,
    output logic signed [OUT_W-1:0]   tangent_z,
    output logic                      zero_length
);

    // front end to queue
    logic     q_wr;
    cmd_t     q_wdata;
    logic     q_full;
    logic     clearing;

    // queue to back end
    cmd_t     q_head;
    logic     q_empty;
    logic     cmd_take;

    // back end to divider
    div_req_t div_req;
    div_rsp_t div_rsp;

    logic     out_valid;

    mta_front u_front (
        .push         (push),
        .full         (full),
        .op           (op),
        .vertex_index (vertex_index),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .tex_u        (tex_u),
        .tex_v        (tex_v),
        .corner0      (corner0),
        .corner1      (corner1),
        .corner2      (corner2),
        .q_full       (q_full),
        .clearing     (clearing),
        .q_wr         (q_wr),
        .q_data       (q_wdata)
    );

    mta_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (q_wdata),
        .rd_en   (cmd_take),
        .rd_data (q_head),
        .full    (q_full),
        .empty   (q_empty)
    );

    mta_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // result register lives in the back end; pop only counts while it holds an item
    mta_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!q_empty),
        .cmd       (q_head),
        .cmd_take  (cmd_take),
        .clearing  (clearing),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .out_pop   (pop && out_valid),
        .out_valid (out_valid),
        .out_x     (tangent_x),
        .out_y     (tangent_y),
        .out_z     (tangent_z),
        .out_zl    (zero_length)
    );

    assign empty = !out_valid;

endmodule
